@@ rtl/gtle_pkg.sv @@
// ----------------------------------------------------------------------------
// gtle_pkg
// Shared types, constants and helper functions of the GBK text layout engine.
// ----------------------------------------------------------------------------
package gtle_pkg;

  // GBK font rows are CODES_PER_ROW codes wide.
  localparam int CODES_PER_ROW = 190;
  localparam int LEAD_ROWS     = 125;
  localparam int IDX_W         = $clog2(LEAD_ROWS * CODES_PER_ROW + 190);
  localparam int OFF_W         = IDX_W + 7;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Byte codes.
  localparam logic [7:0] LEAD_MIN      = 8'h81;
  localparam logic [7:0] TRAIL_MIN     = 8'h40;
  localparam logic [7:0] BYTE_FF       = 8'hff;
  localparam logic [7:0] TRAIL_SPLIT   = 8'h7f;
  localparam logic [7:0] TRAIL_HI_BASE = 8'h41;
  localparam logic [7:0] SINGLE_MAX    = 8'h80;
  localparam logic [7:0] CHAR_CR       = 8'd13;
  localparam logic [7:0] CHAR_NUL      = 8'd0;

  // Result kinds.
  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_GLYPH = 2'd1;
  localparam logic [1:0] KIND_BLANK = 2'd2;

  // Font size codes.
  localparam logic [1:0] FONT_SMALL  = 2'd0;
  localparam logic [1:0] FONT_MEDIUM = 2'd1;

  // Configuration register indexes.
  localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
  localparam logic [2:0] REG_AREA_WIDTH  = 3'd2;
  localparam logic [2:0] REG_AREA_HEIGHT = 3'd3;
  localparam logic [2:0] REG_FONT_SIZE   = 3'd4;
  localparam logic [2:0] REG_BASE_SMALL  = 3'd5;
  localparam logic [2:0] REG_BASE_MEDIUM = 3'd6;
  localparam logic [2:0] REG_BASE_LARGE  = 3'd7;

  typedef enum logic [1:0] {
    OP_ZERO,
    OP_GLYPH,
    OP_CR,
    OP_CHAR
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] lead;
    logic [7:0] data;
  } q_entry_t;

  typedef struct packed {
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [15:0] area_width;
    logic [15:0] area_height;
    logic [1:0]  font_size;
    logic [23:0] base_small;
    logic [23:0] base_medium;
    logic [23:0] base_large;
  } cfg_t;

  function automatic logic [4:0] font_height(input logic [1:0] size);
    logic [4:0] h;
    case (size)
      FONT_SMALL:  h = 5'd12;
      FONT_MEDIUM: h = 5'd16;
      default:     h = 5'd24;
    endcase
    return h;
  endfunction

  function automatic logic [6:0] font_bytes(input logic [1:0] size);
    logic [6:0] n;
    case (size)
      FONT_SMALL:  n = 7'd24;
      FONT_MEDIUM: n = 7'd32;
      default:     n = 7'd72;
    endcase
    return n;
  endfunction

endpackage

@@ rtl/gbk_text_layout_engine.sv @@
// Results: a character or blank glyph result is registered straight from the queued entry of its byte; a
// GBK glyph with a flash address passes the index, offset and address registers first.
// Throughput: one byte per cycle while the queue is not full, except that a GBK trail byte with a valid
// code holds the back end for its steps (index, multiply by glyph size, base add).
// Reset: configuration registers return to their defaults, the cursor to (0, 0), the queue empties.
// ----------------------------------------------------------------------------
// gbk_text_layout_engine
// Lays out a byte string of ASCII and GBK characters in a text area and
// produces one draw command per visible character.
// ----------------------------------------------------------------------------
module gbk_text_layout_engine import gtle_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  text_byte_i,
  input  logic        pop,
  output logic        empty,
  output logic [1:0]  command_kind_o,
  output logic [15:0] pos_x_o,
  output logic [15:0] pos_y_o,
  output logic [7:0]  char_code_o,
  output logic [23:0] glyph_address_o,
  output logic [6:0]  glyph_bytes_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  cfg_t     cfg_q, cfg_d;
  logic     q_full, q_push, q_empty, q_pop, back_busy;
  q_entry_t q_in, q_out;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ORIGIN_X:    cfg_d.origin_x    = cfg_data_i[15:0];
        REG_ORIGIN_Y:    cfg_d.origin_y    = cfg_data_i[15:0];
        REG_AREA_WIDTH:  cfg_d.area_width  = cfg_data_i[15:0];
        REG_AREA_HEIGHT: cfg_d.area_height = cfg_data_i[15:0];
        REG_FONT_SIZE:   cfg_d.font_size   = cfg_data_i[1:0];
        REG_BASE_SMALL:  cfg_d.base_small  = cfg_data_i;
        REG_BASE_MEDIUM: cfg_d.base_medium = cfg_data_i;
        REG_BASE_LARGE:  cfg_d.base_large  = cfg_data_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x    <= 16'd0;
      cfg_q.origin_y    <= 16'd0;
      cfg_q.area_width  <= 16'd240;
      cfg_q.area_height <= 16'd320;
      cfg_q.font_size   <= FONT_MEDIUM;
      cfg_q.base_small  <= 24'd0;
      cfg_q.base_medium <= 24'd0;
      cfg_q.base_large  <= 24'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  gtle_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .text_byte_i (text_byte_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (q_in)
  );

  gtle_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .entry_o (q_out)
  );

  gtle_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .q_empty_i       (q_empty),
    .q_entry_i       (q_out),
    .q_pop_o         (q_pop),
    .busy_o          (back_busy),
    .pop             (pop),
    .empty           (empty),
    .command_kind_o  (command_kind_o),
    .pos_x_o         (pos_x_o),
    .pos_y_o         (pos_y_o),
    .char_code_o     (char_code_o),
    .glyph_address_o (glyph_address_o),
    .glyph_bytes_o   (glyph_bytes_o)
  );

`ifndef ASSERT_OFF
  // While an address is being computed the result slot must stay free.
  a_busy_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_busy |-> empty)
    else $error("result slot occupied during address calculation");

  a_char_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && command_kind_o == KIND_CHAR) |->
      (glyph_bytes_o == 7'd0 && glyph_address_o == 24'd0))
    else $error("character result carries glyph fields");

  a_glyph_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && command_kind_o != KIND_CHAR) |->
      (char_code_o == 8'd0 &&
       (glyph_bytes_o == 7'd24 || glyph_bytes_o == 7'd32 || glyph_bytes_o == 7'd72)))
    else $error("glyph result has bad byte count or char code");

  a_blank_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && command_kind_o == KIND_BLANK) |-> glyph_address_o == 24'd0)
    else $error("blank glyph has a flash address");
`endif

endmodule

@@ rtl/gtle_front.sv @@
// ----------------------------------------------------------------------------
// gtle_front
// Accepts string bytes, pairs GBK lead and trail bytes and classifies each
// byte into an operation for the back end.
// ----------------------------------------------------------------------------
module gtle_front import gtle_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] text_byte_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output q_entry_t   q_entry_o
);

  logic       accept;
  logic       pend_q, pend_d;
  logic [7:0] lead_q, lead_d;
  logic       hold_lead;

  assign full   = q_full_i;
  assign accept = push & ~q_full_i;

  // A byte above the single-width range with no lead waiting is held and
  // produces no operation of its own.
  assign hold_lead = ~pend_q && (text_byte_i > SINGLE_MAX);

  always_comb begin
    pend_d         = pend_q;
    lead_d         = lead_q;
    q_entry_o.lead = lead_q;
    q_entry_o.data = text_byte_i;
    q_entry_o.op   = OP_CHAR;
    if (text_byte_i == CHAR_NUL) begin
      q_entry_o.op = OP_ZERO;
    end else if (pend_q) begin
      q_entry_o.op = OP_GLYPH;
    end else if (text_byte_i == CHAR_CR) begin
      q_entry_o.op = OP_CR;
    end
    if (accept) begin
      if (text_byte_i == CHAR_NUL) begin
        pend_d = 1'b0;
      end else if (pend_q) begin
        pend_d = 1'b0;
      end else if (hold_lead) begin
        pend_d = 1'b1;
        lead_d = text_byte_i;
      end
    end
  end

  assign q_push_o = accept & ~hold_lead;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      lead_q <= 8'd0;
    end else begin
      pend_q <= pend_d;
      lead_q <= lead_d;
    end
  end

endmodule

@@ rtl/gtle_queue.sv @@
// ----------------------------------------------------------------------------
// gtle_queue
// Short first-in first-out queue of classified operations between the front
// end and the back end.
// ----------------------------------------------------------------------------
module gtle_queue import gtle_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t entry_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output q_entry_t entry_o
);

  q_entry_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

@@ rtl/gtle_back.sv @@
// ----------------------------------------------------------------------------
// gtle_back
// Executes classified operations: cursor placement, wrap and stop tests,
// glyph address calculation and the result register.
// ----------------------------------------------------------------------------
module gtle_back import gtle_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        q_empty_i,
  input  q_entry_t    q_entry_i,
  output logic        q_pop_o,
  output logic        busy_o,
  input  logic        pop,
  output logic        empty,
  output logic [1:0]  command_kind_o,
  output logic [15:0] pos_x_o,
  output logic [15:0] pos_y_o,
  output logic [7:0]  char_code_o,
  output logic [23:0] glyph_address_o,
  output logic [6:0]  glyph_bytes_o
);

  localparam logic [1:0] ST_EXEC  = 2'd0;
  localparam logic [1:0] ST_SCALE = 2'd1;
  localparam logic [1:0] ST_ADD   = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [15:0]      cx_q, cx_d, cy_q, cy_d;
  logic             afull_q, afull_d;
  logic             rvalid_q, rvalid_d;
  logic [1:0]       kind_q, kind_d;
  logic [15:0]      px_q, px_d, py_q, py_d;
  logic [7:0]       code_q, code_d;
  logic [23:0]      addr_q, addr_d;
  logic [6:0]       nb_q, nb_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [OFF_W-1:0] off_q, off_d;

  logic [4:0]         s, w, item_w;
  logic [6:0]         nbytes;
  logic [23:0]        base;
  logic signed [17:0] right, bottom;
  logic               wrap, stop, out_free, take, code_ok;
  logic [15:0]        cx_w, cy_w;
  logic [7:0]         col;
  logic [6:0]         row;

  assign s      = font_height(cfg_i.font_size);
  assign w      = s >> 1;
  assign nbytes = font_bytes(cfg_i.font_size);

  always_comb begin
    case (cfg_i.font_size)
      FONT_SMALL:  base = cfg_i.base_small;
      FONT_MEDIUM: base = cfg_i.base_medium;
      default:     base = cfg_i.base_large;
    endcase
  end

  assign item_w = (q_entry_i.op == OP_GLYPH) ? s : w;
  assign right  = $signed({2'b00, cfg_i.origin_x} + {2'b00, cfg_i.area_width}
                          - {13'd0, item_w});
  assign bottom = $signed({2'b00, cfg_i.origin_y} + {2'b00, cfg_i.area_height}
                          - {13'd0, s});
  assign wrap   = $signed({2'b00, cx_q}) > right;
  assign cx_w   = wrap ? cfg_i.origin_x : cx_q;
  assign cy_w   = wrap ? cy_q + 16'(s) : cy_q;
  assign stop   = $signed({2'b00, cy_w}) > bottom;

  assign code_ok = !(q_entry_i.lead == BYTE_FF || q_entry_i.data < TRAIL_MIN ||
                     q_entry_i.data == BYTE_FF);
  assign col = (q_entry_i.data < TRAIL_SPLIT) ? q_entry_i.data - TRAIL_MIN
                                               : q_entry_i.data - TRAIL_HI_BASE;
  assign row = 7'(q_entry_i.lead - LEAD_MIN);

  // The result slot is free when empty or when its transaction completes now.
  assign out_free = ~rvalid_q | pop;
  assign take     = (state_q == ST_EXEC) & ~q_empty_i & out_free;
  assign q_pop_o  = take;
  assign busy_o   = (state_q != ST_EXEC);

  always_comb begin
    state_d  = state_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    afull_d  = afull_q;
    rvalid_d = rvalid_q & ~pop;
    kind_d   = kind_q;
    px_d     = px_q;
    py_d     = py_q;
    code_d   = code_q;
    addr_d   = addr_q;
    nb_d     = nb_q;
    idx_d    = idx_q;
    off_d    = off_q;
    case (state_q)
      ST_EXEC: begin
        if (take) begin
          if (q_entry_i.op == OP_ZERO) begin
            cx_d    = cfg_i.origin_x;
            cy_d    = cfg_i.origin_y;
            afull_d = 1'b0;
          end else if (!afull_q) begin
            cx_d = cx_w;
            cy_d = cy_w;
            if (stop) begin
              afull_d = 1'b1;
            end else begin
              case (q_entry_i.op)
                OP_GLYPH: begin
                  px_d   = cx_w;
                  py_d   = cy_w;
                  code_d = 8'd0;
                  addr_d = 24'd0;
                  nb_d   = nbytes;
                  cx_d   = cx_w + 16'(s);
                  if (code_ok) begin
                    kind_d  = KIND_GLYPH;
                    idx_d   = IDX_W'(row) * IDX_W'(CODES_PER_ROW) + IDX_W'(col);
                    state_d = ST_SCALE;
                  end else begin
                    kind_d   = KIND_BLANK;
                    rvalid_d = 1'b1;
                  end
                end
                OP_CR: begin
                  cx_d = cfg_i.origin_x;
                  cy_d = cy_w + 16'(s);
                end
                default: begin
                  kind_d   = KIND_CHAR;
                  px_d     = cx_w;
                  py_d     = cy_w;
                  code_d   = q_entry_i.data;
                  addr_d   = 24'd0;
                  nb_d     = 7'd0;
                  cx_d     = cx_w + 16'(w);
                  rvalid_d = 1'b1;
                end
              endcase
            end
          end
        end
      end
      ST_SCALE: begin
        off_d   = OFF_W'(idx_q) * OFF_W'(nb_q);
        state_d = ST_ADD;
      end
      ST_ADD: begin
        addr_d   = base + 24'(off_q);
        rvalid_d = 1'b1;
        state_d  = ST_EXEC;
      end
      default: begin
        state_d = ST_EXEC;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_EXEC;
      cx_q     <= 16'd0;
      cy_q     <= 16'd0;
      afull_q  <= 1'b0;
      rvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cx_q     <= cx_d;
      cy_q     <= cy_d;
      afull_q  <= afull_d;
      rvalid_q <= rvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    px_q   <= px_d;
    py_q   <= py_d;
    code_q <= code_d;
    addr_q <= addr_d;
    nb_q   <= nb_d;
    idx_q  <= idx_d;
    off_q  <= off_d;
  end

  assign empty           = ~rvalid_q;
  assign command_kind_o  = kind_q;
  assign pos_x_o         = px_q;
  assign pos_y_o         = py_q;
  assign char_code_o     = code_q;
  assign glyph_address_o = addr_q;
  assign glyph_bytes_o   = nb_q;

endmodule
